// ===== src/dsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared constants, codes and controller/datapath handshake types for the
// direct-mapped sector cache.
// ----------------------------------------------------------------------------
package dsc_pkg;

    // Default geometry
    localparam int DSC_CACHE_LINES  = 128;
    localparam int DSC_SECTOR_BYTES = 512;

    // Fixed field widths
    localparam int DSC_LBA_W  = 32;
    localparam int DSC_DISK_W = 8;
    localparam int DSC_WORD_W = 64;
    localparam int DSC_CNT_W  = 32;

    // Address bits folded into the slot remainder per cycle
    localparam int DSC_REM_BITS = 4;

    // Action codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FILL   = 1'b1;

    // Result kind codes
    localparam logic KIND_HIT  = 1'b0;
    localparam logic KIND_MISS = 1'b1;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;       // capture the input word and start the slot calculation
        logic addr_load;  // latch slot base address
        logic clear_wr;   // clear one tag entry during the reset sweep
        logic fill_wr;    // write one fill word and update the tag
        logic hit_inc;    // count a hit
        logic miss_emit;  // count a miss and present the miss result
        logic data_rd;    // read one sector word and present it
    } dsc_cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic rem_busy;    // slot calculation still running
        logic clear_last;  // final tag entry of the reset sweep
        logic is_fill;     // captured word is a fill
        logic tag_hit;     // slot valid and tag matches
        logic read_last;   // current read is the last sector word
    } dsc_stat_t;

endpackage

// ===== src/dsc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dsc_slot_rem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_slot_rem
// Slot index as lba mod CACHE_LINES. A power-of-two line count takes the low
// address bits; any other count runs a restoring remainder, four bits a cycle.
// ----------------------------------------------------------------------------
module dsc_slot_rem
    import dsc_pkg::*;
#(
    parameter int CACHE_LINES = DSC_CACHE_LINES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DSC_LBA_W-1:0]           lba,
    output logic                           busy,
    output logic [$clog2(CACHE_LINES)-1:0] slot
);

    localparam int LineW = $clog2(CACHE_LINES);

    generate
        if ((CACHE_LINES & (CACHE_LINES - 1)) == 0)
        begin : g_mask
            logic [LineW-1:0] slot_reg;

            // Take the low address bits
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    slot_reg <= '0;
                end
                else if (start)
                begin
                    slot_reg <= lba[LineW-1:0];
                end
            end

            assign busy = 1'b0;
            assign slot = slot_reg;
        end
        else
        begin : g_div
            localparam int Steps = DSC_LBA_W / DSC_REM_BITS;
            localparam int CntW  = $clog2(Steps);
            localparam logic [LineW:0] Lines = (LineW + 1)'(CACHE_LINES);

            logic [LineW-1:0]     rem_reg, rem_next;
            logic [DSC_LBA_W-1:0] shift_reg;
            logic [CntW-1:0]      cnt_reg;
            logic                 run_reg;

            // Fold the next four address bits into the remainder
            always_comb
            begin
                logic [LineW:0]   t;
                logic [LineW-1:0] r;
                r = rem_reg;
                for (int i = 0; i < DSC_REM_BITS; i++)
                begin
                    t = {r, shift_reg[DSC_LBA_W-1-i]};
                    if (t >= Lines)
                    begin
                        t = t - Lines;
                    end
                    r = t[LineW-1:0];
                end
                rem_next = r;
            end

            // Step control
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    run_reg <= 1'b0;
                    cnt_reg <= '0;
                end
                else if (start)
                begin
                    run_reg <= 1'b1;
                    cnt_reg <= '0;
                end
                else if (run_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CntW'(Steps - 1))
                    begin
                        run_reg <= 1'b0;
                    end
                end
            end

            // Remainder and address shifter
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg   <= '0;
                    shift_reg <= lba;
                end
                else if (run_reg)
                begin
                    rem_reg   <= rem_next;
                    shift_reg <= shift_reg << DSC_REM_BITS;
                end
            end

            assign busy = run_reg;
            assign slot = rem_reg;
        end
    endgenerate

endmodule

// ===== src/dsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_ctrl
// Sequencer for the sector cache: tag clear sweep after reset, slot
// calculation, fill write, tag compare and hit streaming.
// ----------------------------------------------------------------------------
module dsc_ctrl
    import dsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  dsc_stat_t stat,
    output dsc_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SLOT   = 6'b000100,
        S_FILL   = 6'b001000,
        S_LOOKUP = 6'b010000,
        S_STREAM = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                if (!stat.rem_busy)
                begin
                    cmd.addr_load = 1'b1;
                    state_next    = stat.is_fill ? S_FILL : S_LOOKUP;
                end
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_LOOKUP:
            begin
                if (stat.tag_hit)
                begin
                    cmd.hit_inc = 1'b1;
                    cmd.data_rd = 1'b1;
                    state_next  = stat.read_last ? S_IDLE : S_STREAM;
                end
                else
                begin
                    cmd.miss_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_STREAM:
            begin
                cmd.data_rd = 1'b1;
                if (stat.read_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== src/dsc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_dpath
// Datapath of the sector cache: input capture, slot and base address, tag and
// sector RAMs, fill position, hit/miss counters and result registers.
// ----------------------------------------------------------------------------
module dsc_dpath
    import dsc_pkg::*;
#(
    parameter int CACHE_LINES  = DSC_CACHE_LINES,
    parameter int SECTOR_BYTES = DSC_SECTOR_BYTES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsc_cmd_t              cmd,
    output dsc_stat_t             stat,
    input  logic                  action,
    input  logic [DSC_DISK_W-1:0] disk_id,
    input  logic [DSC_LBA_W-1:0]  lba,
    input  logic [DSC_WORD_W-1:0] fill_word,
    input  logic                  fill_last,
    output logic                  result_valid,
    output logic                  kind,
    output logic [DSC_WORD_W-1:0] read_word,
    output logic                  last,
    output logic [DSC_CNT_W-1:0]  hit_count,
    output logic [DSC_CNT_W-1:0]  miss_count
);

    localparam int SectorWords = SECTOR_BYTES / 8;
    localparam int LineW       = $clog2(CACHE_LINES);
    localparam int PosW        = $clog2(SectorWords);
    localparam int DataDepth   = CACHE_LINES * SectorWords;
    localparam int AddrW       = $clog2(DataDepth);
    localparam int TagW        = 1 + DSC_DISK_W + DSC_LBA_W;
    localparam logic [AddrW-1:0] WordsPerLine = AddrW'(SectorWords);
    localparam logic [PosW-1:0]  PosLast      = PosW'(SectorWords - 1);
    localparam logic [LineW-1:0] LineLast     = LineW'(CACHE_LINES - 1);

    // Captured input word
    logic                  action_reg;
    logic [DSC_DISK_W-1:0] disk_reg;
    logic [DSC_LBA_W-1:0]  lba_reg;
    logic [DSC_WORD_W-1:0] fill_word_reg;
    logic                  fill_last_reg;

    logic [LineW-1:0] slot;
    logic             rem_busy;
    logic [AddrW-1:0] base_reg;

    logic [LineW-1:0] clr_idx_reg;
    logic [PosW-1:0]  pos_reg;
    logic [PosW-1:0]  idx_reg;

    logic             tag_we;
    logic [LineW-1:0] tag_waddr;
    logic [TagW-1:0]  tag_wdata;
    logic [TagW-1:0]  tag_rdata;
    logic [DSC_WORD_W-1:0] data_rdata;

    logic                 result_valid_reg;
    logic                 kind_reg;
    logic                 last_reg;
    logic [DSC_CNT_W-1:0] hits_reg;
    logic [DSC_CNT_W-1:0] misses_reg;

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg    <= action;
            disk_reg      <= disk_id;
            lba_reg       <= lba;
            fill_word_reg <= fill_word;
            fill_last_reg <= fill_last;
        end
    end

    // Slot index
    dsc_slot_rem #(
        .CACHE_LINES (CACHE_LINES)
    ) u_slot_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .lba   (lba),
        .busy  (rem_busy),
        .slot  (slot)
    );

    // Sector base address in the data RAM
    always_ff @(posedge clk)
    begin
        if (cmd.addr_load)
        begin
            base_reg <= AddrW'(AddrW'(slot) * WordsPerLine);
        end
    end

    // Clear sweep, fill position and stream index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            pos_reg     <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.fill_wr)
            begin
                if (fill_last_reg || pos_reg == PosLast)
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.data_rd)
            begin
                idx_reg <= (idx_reg == PosLast) ? '0 : idx_reg + 1'b1;
            end
        end
    end

    // Tag write: clear sweep or fill (valid only on the final fill word)
    always_comb
    begin
        tag_we    = cmd.clear_wr | cmd.fill_wr;
        tag_waddr = cmd.clear_wr ? clr_idx_reg : slot;
        tag_wdata = cmd.clear_wr ? '0 : {fill_last_reg, disk_reg, lba_reg};
    end

    dsc_ram #(
        .WIDTH (TagW),
        .DEPTH (CACHE_LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (slot),
        .rdata (tag_rdata)
    );

    dsc_ram #(
        .WIDTH (DSC_WORD_W),
        .DEPTH (DataDepth)
    ) u_data_ram (
        .clk   (clk),
        .we    (cmd.fill_wr),
        .waddr (base_reg + AddrW'(pos_reg)),
        .wdata (fill_word_reg),
        .raddr (base_reg + AddrW'(idx_reg)),
        .rdata (data_rdata)
    );

    // Counters and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            kind_reg         <= KIND_HIT;
            last_reg         <= 1'b0;
            hits_reg         <= '0;
            misses_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= cmd.data_rd | cmd.miss_emit;
            if (cmd.hit_inc)
            begin
                hits_reg <= hits_reg + 1'b1;
            end
            if (cmd.miss_emit)
            begin
                misses_reg <= misses_reg + 1'b1;
                kind_reg   <= KIND_MISS;
                last_reg   <= 1'b1;
            end
            else if (cmd.data_rd)
            begin
                kind_reg <= KIND_HIT;
                last_reg <= (idx_reg == PosLast);
            end
        end
    end

    // Status
    always_comb
    begin
        stat.rem_busy   = rem_busy;
        stat.clear_last = (clr_idx_reg == LineLast);
        stat.is_fill    = (action_reg == ACT_FILL);
        stat.tag_hit    = tag_rdata[TagW-1] && (tag_rdata[TagW-2:DSC_LBA_W] == disk_reg)
                          && (tag_rdata[DSC_LBA_W-1:0] == lba_reg);
        stat.read_last  = (idx_reg == PosLast);
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign read_word    = (kind_reg == KIND_MISS) ? '0 : data_rdata;
    assign last         = last_reg;
    assign hit_count    = hits_reg;
    assign miss_count   = misses_reg;

endmodule

// ===== src/disk_sector_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_sector_cache
// Direct-mapped sector cache with hit streaming and fill from disk.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. After reset the tag RAM
// is swept clear entry by entry with busy high. A fill word or a miss keeps
// busy high through the slot calculation and the tag write or compare; a hit
// keeps it high until the last sector word is read, the one read port of the
// sector RAM giving one word a cycle. A line count that is not a power of two
// adds the lba mod CACHE_LINES remainder steps to every word. Results appear
// for one cycle each, marked by result_valid, and cannot be held off: a hit
// gives SECTOR_BYTES/8 words on consecutive cycles, the final one with last
// set; a miss gives one result with kind set.
// ----------------------------------------------------------------------------
module disk_sector_cache
    import dsc_pkg::*;
#(
    parameter int CACHE_LINES  = DSC_CACHE_LINES,
    parameter int SECTOR_BYTES = DSC_SECTOR_BYTES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [DSC_DISK_W-1:0] disk_id,
    input  logic [DSC_LBA_W-1:0]  lba,
    input  logic [DSC_WORD_W-1:0] fill_word,
    input  logic                  fill_last,
    output logic                  result_valid,
    output logic                  kind,
    output logic [DSC_WORD_W-1:0] read_word,
    output logic                  last,
    output logic [DSC_CNT_W-1:0]  hit_count,
    output logic [DSC_CNT_W-1:0]  miss_count
);

    dsc_cmd_t  cmd;
    dsc_stat_t stat;

    // Sequencer
    dsc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Storage and result path
    dsc_dpath #(
        .CACHE_LINES  (CACHE_LINES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .disk_id      (disk_id),
        .lba          (lba),
        .fill_word    (fill_word),
        .fill_last    (fill_last),
        .result_valid (result_valid),
        .kind         (kind),
        .read_word    (read_word),
        .last         (last),
        .hit_count    (hit_count),
        .miss_count   (miss_count)
    );

endmodule

// ===== tb/sv/disk_sector_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_sector_cache_tb
// Self-checking bench for the direct-mapped sector cache. Lookups and fill
// words are driven through the start/busy handshake. A cycle-free model of the
// tag store, sector data and counters predicts every hit word and miss result,
// and each strobed result is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module disk_sector_cache_tb;
    import dsc_pkg::*;

    localparam int LINES        = DSC_CACHE_LINES;
    localparam int SECTOR_WORDS = DSC_SECTOR_BYTES / 8;
    localparam int RANDOM_ITEMS = 180;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 2 * SECTOR_WORDS + 8;
    localparam int POOL_SIZE    = 8;

    typedef struct packed {
        logic                  kind;
        logic [DSC_WORD_W-1:0] read_word;
        logic                  last;
        logic [DSC_CNT_W-1:0]  hit_count;
        logic [DSC_CNT_W-1:0]  miss_count;
    } sector_result_t;

    // Tag store, sector data and counters of the cache, plus the queue of
    // results still owed by the block
    class sector_cache_board;
        bit                    valid_tab [LINES];
        logic [DSC_DISK_W-1:0] disk_tab [LINES];
        logic [DSC_LBA_W-1:0]  block_tab [LINES];
        logic [DSC_WORD_W-1:0] data_tab [LINES][SECTOR_WORDS];
        bit [SECTOR_WORDS-1:0] written_tab [LINES];
        int unsigned           fill_pos;
        logic [DSC_CNT_W-1:0]  hits;
        logic [DSC_CNT_W-1:0]  misses;
        sector_result_t        awaited [$];
        int                    errors;

        function new();
            fill_pos = 0;
            hits     = '0;
            misses   = '0;
            errors   = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // True when a lookup would hit a line holding a word never written
        function bit reads_unwritten(logic [DSC_DISK_W-1:0] disk, logic [DSC_LBA_W-1:0] blk);
            int slot;
            slot = int'(blk % LINES);
            return valid_tab[slot] && disk_tab[slot] == disk && block_tab[slot] == blk
                && written_tab[slot] != '1;
        endfunction

        function void note_word(logic act, logic [DSC_DISK_W-1:0] disk,
                                logic [DSC_LBA_W-1:0] blk, logic [DSC_WORD_W-1:0] word,
                                logic fl);
            int             slot;
            int unsigned    pos;
            sector_result_t r;
            slot = int'(blk % LINES);
            if (act == ACT_FILL)
            begin
                // Write at the shared position; the line is invalid until the last word
                pos = (fill_pos >= SECTOR_WORDS) ? 0 : fill_pos;
                valid_tab[slot]         = 1'b0;
                data_tab[slot][pos]     = word;
                written_tab[slot][pos]  = 1'b1;
                if (fl)
                begin
                    valid_tab[slot] = 1'b1;
                    disk_tab[slot]  = disk;
                    block_tab[slot] = blk;
                    fill_pos        = 0;
                end
                else
                    fill_pos = (pos + 1 >= SECTOR_WORDS) ? 0 : pos + 1;
            end
            else if (valid_tab[slot] && disk_tab[slot] == disk && block_tab[slot] == blk)
            begin
                // Stream the whole sector
                hits = hits + 1'b1;
                for (int k = 0; k < SECTOR_WORDS; k++)
                begin
                    r.kind       = KIND_HIT;
                    r.read_word  = data_tab[slot][k];
                    r.last       = (k == SECTOR_WORDS - 1);
                    r.hit_count  = hits;
                    r.miss_count = misses;
                    awaited.push_back(r);
                end
            end
            else
            begin
                misses       = misses + 1'b1;
                r.kind       = KIND_MISS;
                r.read_word  = '0;
                r.last       = 1'b1;
                r.hit_count  = hits;
                r.miss_count = misses;
                awaited.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(sector_result_t got);
            sector_result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual kind=%0b word=%h",
                         $time, got.kind, got.read_word);
                return;
            end
            want = awaited.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("read_word", want.read_word, got.read_word);
            compare_field("last", want.last, got.last);
            compare_field("hit_count", want.hit_count, got.hit_count);
            compare_field("miss_count", want.miss_count, got.miss_count);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  action = ACT_LOOKUP;
    logic [DSC_DISK_W-1:0] disk_id = '0;
    logic [DSC_LBA_W-1:0]  lba = '0;
    logic [DSC_WORD_W-1:0] fill_word = '0;
    logic                  fill_last = 1'b0;
    logic                  busy;
    logic                  result_valid;
    logic                  kind;
    logic [DSC_WORD_W-1:0] read_word;
    logic                  last;
    logic [DSC_CNT_W-1:0]  hit_count;
    logic [DSC_CNT_W-1:0]  miss_count;

    sector_cache_board     board = new();
    int unsigned           idle_pct = 0;
    int unsigned           words_sent = 0;
    int unsigned           stall_cycles = 0;
    logic [DSC_DISK_W-1:0] pool_disk [POOL_SIZE];
    logic [DSC_LBA_W-1:0]  pool_lba [POOL_SIZE];

    disk_sector_cache uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .disk_id      (disk_id),
        .lba          (lba),
        .fill_word    (fill_word),
        .fill_last    (fill_last),
        .result_valid (result_valid),
        .kind         (kind),
        .read_word    (read_word),
        .last         (last),
        .hit_count    (hit_count),
        .miss_count   (miss_count)
    );

    // Generate the clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result({kind, read_word, last, hit_count, miss_count});
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [DSC_WORD_W-1:0] pick_data();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Present one word, idle at random first, and hold it until taken
    task automatic send_word(input logic act, input logic [DSC_DISK_W-1:0] disk,
                             input logic [DSC_LBA_W-1:0] blk,
                             input logic [DSC_WORD_W-1:0] word, input logic fl);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        action    <= act;
        disk_id   <= disk;
        lba       <= blk;
        fill_word <= word;
        fill_last <= fl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_word(act, disk, blk, word, fl);
        words_sent++;
    endtask

    task automatic lookup(input logic [DSC_DISK_W-1:0] disk, input logic [DSC_LBA_W-1:0] blk);
        // Steer away from a hit on a line that was never wholly written
        if (board.reads_unwritten(disk, blk))
            disk = disk ^ 8'h01;
        send_word(ACT_LOOKUP, disk, blk, {$urandom, $urandom}, 1'($urandom_range(1)));
    endtask

    // Send a run of fill words, the final one marked last, with a rare stray
    // word to another sector slipped in
    task automatic fill_sector(input logic [DSC_DISK_W-1:0] disk,
                               input logic [DSC_LBA_W-1:0] blk, input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(31) == 0 && n != count - 1)
                send_word(ACT_FILL, DSC_DISK_W'($urandom),
                          pool_lba[$urandom_range(POOL_SIZE - 1)], pick_data(), 1'b0);
            send_word(ACT_FILL, disk, blk, pick_data(), n == count - 1);
        end
    endtask

    initial
    begin
        int unsigned phase_pct [4];
        int unsigned base;
        int unsigned p;
        int unsigned choice;

        phase_pct = '{0, 49, 0, 14};

        // Build a working set with shared slots, shared blocks and the extremes
        pool_disk[0] = 8'hFF;  pool_lba[0] = 32'hFFFF_FFFF;
        pool_disk[1] = 8'h00;  pool_lba[1] = 32'h0000_0000;
        pool_disk[2] = 8'hFF;  pool_lba[2] = 32'hFFFF_FFFF - LINES;
        pool_disk[3] = 8'hFE;  pool_lba[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            pool_disk[i] = DSC_DISK_W'($urandom);
            pool_lba[i]  = $urandom;
        end
        pool_lba[5]  = pool_lba[4] + LINES * $urandom_range(1, 1000);
        pool_disk[6] = pool_disk[4] ^ 8'h80;
        pool_lba[6]  = pool_lba[4];

        // Hold reset, then release on an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Lookups into the cleared cache miss at both ends of the ranges
        lookup(8'h00, 32'h0000_0000);
        lookup(8'hFF, 32'hFFFF_FFFF);
        // Fill without last, then an early last: a short sector goes valid
        send_word(ACT_FILL, 8'h01, 32'd5, '0, 1'b0);
        send_word(ACT_FILL, 8'h01, 32'd5, '1, 1'b0);
        send_word(ACT_FILL, 8'h01, 32'd5, pick_data(), 1'b0);
        send_word(ACT_FILL, 8'h01, 32'd5, pick_data(), 1'b1);
        lookup(8'h02, 32'd5);
        lookup(8'h01, 32'd5 + LINES);
        // Interleave fills of two slots on the shared word count
        send_word(ACT_FILL, 8'h07, 32'd6, pick_data(), 1'b0);
        send_word(ACT_FILL, 8'h08, 32'd9, pick_data(), 1'b0);
        send_word(ACT_FILL, 8'h07, 32'd6, pick_data(), 1'b1);
        // Whole sector at the top slot, then a hit, a disk mismatch and a block mismatch
        fill_sector(pool_disk[0], pool_lba[0], SECTOR_WORDS);
        lookup(pool_disk[0], pool_lba[0]);
        lookup(pool_disk[3], pool_lba[3]);
        lookup(pool_disk[2], pool_lba[2]);
        // A fill past the sector end wraps the word count
        fill_sector(pool_disk[1], pool_lba[1], SECTOR_WORDS + 3);
        lookup(pool_disk[1], pool_lba[1]);

        // Random traffic, mostly lookups on the working set
        base = words_sent;
        while (words_sent < base + RANDOM_ITEMS)
        begin
            idle_pct = phase_pct[((words_sent - base) * 4 / RANDOM_ITEMS) % 4];
            p        = $urandom_range(POOL_SIZE - 1);
            choice   = $urandom_range(99);
            if (choice < 8)
                fill_sector(pool_disk[p], pool_lba[p],
                            SECTOR_WORDS + (($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0));
            else if (choice < 15)
                fill_sector(pool_disk[p], pool_lba[p], $urandom_range(1, 12));
            else if (choice < 20)
                repeat ($urandom_range(1, 3))
                    send_word(ACT_FILL, DSC_DISK_W'($urandom), $urandom, pick_data(),
                              $urandom_range(3) == 0);
            else if (choice < 75)
                lookup(pool_disk[p], pool_lba[p]);
            else
                lookup(DSC_DISK_W'($urandom), $urandom);
        end

        // Drain and let the block settle
        idle_pct = 0;
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
